>>> sv/cht_pkg.sv
// Shared types, codes and sizing constants for the chained hash table.
// Used by every module of the block; has no dependencies of its own.
package cht_pkg;

    // Default table geometry
    localparam int BUCKET_COUNT_DEF = 10;
    localparam int BUCKET_DEPTH_DEF = 8;

    // Fixed field widths
    localparam int KEY_W     = 31;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int IDX_OUT_W = 4;
    localparam int BKT_MAX_W = 6;   // enough for the largest bucket count

    // Hashing: key mod bucket count, a few key bits per cycle
    localparam int HASH_BITS  = 4;
    localparam int HASH_STEPS = (KEY_W + HASH_BITS - 1) / HASH_BITS;
    localparam int SH_W       = HASH_STEPS * HASH_BITS;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // One hashed request on its way from front to back
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [KEY_W-1:0]     key;
        logic [BKT_MAX_W-1:0] bkt;
    } t_job;

endpackage

>>> sv/chained_hash_table_top.sv
// Chained hash table: each item inserts, searches or removes a 31-bit key in
// bucket (key mod BUCKET_COUNT) and gives one result item with a status and
// the bucket index. The front end takes no new item until it has hashed the
// last one in HASH_STEPS steps (eight steps of four key bits each) and passed
// it through a two-entry queue to the back end, which works on one item at a
// time: insert reads the fill count and writes the entry, search and remove
// scan the bucket one entry a cycle through the entry memory's read and write
// ports. Items overlap across the queue, so the sustained rate is set by the
// slower of the two. A full queue or a stalled result item holds the front
// end. No clearing pass runs after reset; the block is ready at once. Depends
// on cht_pkg, cht_front, cht_queue and cht_back.
module chained_hash_table_top #(
    parameter int BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF,
    parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cht_pkg::OP_W-1:0]      i_op,
    input  logic [cht_pkg::KEY_W-1:0]     i_key,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cht_pkg::ST_W-1:0]      o_status,
    output logic [cht_pkg::IDX_OUT_W-1:0] o_bucket_index
);

    logic          push, full, pop, q_valid;
    cht_pkg::t_job push_job, head_job;

    cht_front #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_key      (i_key),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    cht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    cht_back #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_bucket_index (o_bucket_index)
    );

endmodule

>>> sv/cht_front.sv
// Front end: accepts input items and hashes each key to its bucket.
// Depends on cht_pkg; feeds cht_queue.
module cht_front #(
    parameter int BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [cht_pkg::OP_W-1:0]  i_op,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    output logic                      o_push,
    output cht_pkg::t_job             o_job,
    input  logic                      i_full
);

    localparam int BW  = $clog2(BUCKET_COUNT);
    localparam int CW  = $clog2(cht_pkg::HASH_STEPS + 1);

    logic                      r_busy;
    logic [CW-1:0]             r_cnt;
    logic [cht_pkg::SH_W-1:0]  r_sh;
    logic [BW-1:0]             r_rem;
    logic [cht_pkg::OP_W-1:0]  r_op;
    logic [cht_pkg::KEY_W-1:0] r_key;
    logic [BW-1:0]             n_rem;
    logic                      hash_done;

    // Fold the next key bits into the running remainder
    always_comb begin
        logic [BW:0]   t;
        logic [BW-1:0] rem;
        rem = r_rem;
        for (int k = 0; k < cht_pkg::HASH_BITS; k++) begin
            t = {rem, r_sh[cht_pkg::SH_W-1-k]};
            if (t >= (BW+1)'(BUCKET_COUNT)) begin
                t = t - (BW+1)'(BUCKET_COUNT);
            end
            rem = t[BW-1:0];
        end
        n_rem = rem;
    end

    assign hash_done  = (r_cnt == CW'(cht_pkg::HASH_STEPS));
    assign o_in_stall = r_busy;
    assign o_push     = r_busy && hash_done && !i_full;

    assign o_job.op  = r_op;
    assign o_job.key = r_key;
    assign o_job.bkt = cht_pkg::BKT_MAX_W'(r_rem);

    // Control: take an item, hash it, hand it on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (!r_busy) begin
            if (i_in_valid) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end else if (!hash_done) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (!i_full) begin
            r_busy <= 1'b0;
        end
    end

    // Payload: load the key, shift it through the hash
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_in_valid) begin
                r_op  <= i_op;
                r_key <= i_key;
                r_sh  <= cht_pkg::SH_W'(i_key);
                r_rem <= '0;
            end
        end else if (!hash_done) begin
            r_rem <= n_rem;
            r_sh  <= r_sh << cht_pkg::HASH_BITS;
        end
    end

endmodule

>>> sv/cht_queue.sv
// Short queue of hashed items between the front end and the back end.
// Depends on cht_pkg for the item type and depth.
module cht_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cht_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cht_pkg::t_job o_job
);

    localparam int QW = $clog2(cht_pkg::QUEUE_DEPTH);

    cht_pkg::t_job r_mem [cht_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wptr;
    logic [QW-1:0] r_rptr;
    logic [QW:0]   r_cnt;

    assign o_full  = (r_cnt == (QW+1)'(cht_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QW'(cht_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + QW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QW'(cht_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + QW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QW+1)'(1);
            end
        end
    end

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

>>> sv/cht_back.sv
// Back end: runs insert, search and remove against the bucket memories
// and holds the result item. Depends on cht_pkg; fed by cht_queue.
module cht_back #(
    parameter int BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF,
    parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  cht_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cht_pkg::ST_W-1:0]      o_status,
    output logic [cht_pkg::IDX_OUT_W-1:0] o_bucket_index
);

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int AW = $clog2(BUCKET_COUNT * BUCKET_DEPTH);
    localparam int XW = BW + cht_pkg::IDX_OUT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Memories: bucket entries and per-bucket fill counts
    logic [cht_pkg::KEY_W-1:0] r_ent_mem [BUCKET_COUNT * BUCKET_DEPTH];
    logic [FW-1:0]             r_fill_mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0]   r_fill_vld;
    logic [cht_pkg::KEY_W-1:0] r_ent_rd;
    logic [FW-1:0]             r_fill_rd;

    // Sequencer state
    logic [2:0]                       r_state, n_state;
    logic [cht_pkg::OP_W-1:0]         r_op, n_op;
    logic [cht_pkg::KEY_W-1:0]        r_key, n_key;
    logic [BW-1:0]                    r_bkt, n_bkt;
    logic [AW-1:0]                    r_base, n_base;
    logic                             r_fvld, n_fvld;
    logic [FW-1:0]                    r_n, n_n;
    logic [FW-1:0]                    r_idx, n_idx;
    logic [cht_pkg::ST_W-1:0]         r_res, n_res;
    logic                             r_out_valid, n_out_valid;
    logic [cht_pkg::ST_W-1:0]         r_status, n_status;
    logic [cht_pkg::IDX_OUT_W-1:0]    r_obkt, n_obkt;

    // Memory port controls
    logic                      ent_we, ent_re, fill_we, fill_re;
    logic [AW-1:0]             ent_waddr, ent_raddr;
    logic [cht_pkg::KEY_W-1:0] ent_wdata;
    logic [FW-1:0]             fill_wdata;
    logic [BW-1:0]             fill_raddr;

    logic [FW-1:0]   fill_n;
    logic [FW:0]     idx_p1, idx_p2, n_ext;
    logic [XW-1:0]   bkt_ext;

    assign fill_n  = r_fvld ? r_fill_rd : '0;
    assign idx_p1  = (FW+1)'(r_idx) + (FW+1)'(1);
    assign idx_p2  = (FW+1)'(r_idx) + (FW+1)'(2);
    assign n_ext   = (FW+1)'(r_n);
    assign bkt_ext = XW'(r_bkt);

    assign o_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_bucket_index = r_obkt;

    // Sequence one operation over the bucket
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_bkt       = r_bkt;
        n_base      = r_base;
        n_fvld      = r_fvld;
        n_n         = r_n;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_obkt      = r_obkt;
        ent_we      = 1'b0;
        ent_re      = 1'b0;
        ent_waddr   = r_base + AW'(r_idx);
        ent_raddr   = r_base + AW'(idx_p1);
        ent_wdata   = r_ent_rd;
        fill_we     = 1'b0;
        fill_re     = 1'b0;
        fill_raddr  = i_job.bkt[BW-1:0];
        fill_wdata  = r_n - FW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    fill_re = 1'b1;
                    n_op    = i_job.op;
                    n_key   = i_job.key;
                    n_bkt   = i_job.bkt[BW-1:0];
                    n_fvld  = r_fill_vld[i_job.bkt[BW-1:0]];
                    n_base  = AW'(i_job.bkt[BW-1:0]) * AW'(BUCKET_DEPTH);
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_n   = fill_n;
                n_idx = '0;
                n_res = cht_pkg::ST_MISS;
                priority if (r_op == cht_pkg::OP_INSERT) begin
                    if (fill_n >= FW'(BUCKET_DEPTH)) begin
                        n_res = cht_pkg::ST_FULL;
                    end else begin
                        ent_we     = 1'b1;
                        ent_waddr  = r_base + AW'(fill_n);
                        ent_wdata  = r_key;
                        fill_we    = 1'b1;
                        fill_wdata = fill_n + FW'(1);
                        n_res      = cht_pkg::ST_OK;
                    end
                    n_state = S_DONE;
                end else if ((r_op == cht_pkg::OP_SEARCH || r_op == cht_pkg::OP_REMOVE)
                             && fill_n != '0) begin
                    ent_re    = 1'b1;
                    ent_raddr = r_base;
                    n_state   = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                // Compare the entry read last cycle, fetch the next one
                if (r_ent_rd == r_key) begin
                    n_res = cht_pkg::ST_OK;
                    if (r_op == cht_pkg::OP_REMOVE) begin
                        fill_we = 1'b1;
                        if (idx_p1 < n_ext) begin
                            ent_re  = 1'b1;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (idx_p1 < n_ext) begin
                    ent_re  = 1'b1;
                    n_idx   = FW'(idx_p1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // Move the later entry down one place
                ent_we = 1'b1;
                n_idx  = FW'(idx_p1);
                if (idx_p2 < n_ext) begin
                    ent_re    = 1'b1;
                    ent_raddr = r_base + AW'(idx_p2);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res;
                    n_obkt      = bkt_ext[cht_pkg::IDX_OUT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and fill valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fill_vld  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (fill_we) begin
                r_fill_vld[r_bkt] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_bkt    <= n_bkt;
        r_base   <= n_base;
        r_fvld   <= n_fvld;
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_status <= n_status;
        r_obkt   <= n_obkt;
    end

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_rd <= r_ent_mem[ent_raddr];
        end
    end

    // Fill count memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[r_bkt] <= fill_wdata;
        end
        if (fill_re) begin
            r_fill_rd <= r_fill_mem[fill_raddr];
        end
    end

endmodule

>>> sv/cht_checker.sv
// Port-level assertions for chained_hash_table_top, bound to it below.
// Depends on cht_pkg for field widths and status codes.
module cht_checker #(
    parameter int BUCKET_COUNT = cht_pkg::BUCKET_COUNT_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [cht_pkg::OP_W-1:0]      i_op,
    input logic [cht_pkg::KEY_W-1:0]     i_key,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [cht_pkg::ST_W-1:0]      o_status,
    input logic [cht_pkg::IDX_OUT_W-1:0] o_bucket_index
);

    logic [cht_pkg::IDX_OUT_W+6:0] idx_limit;
    assign idx_limit = (cht_pkg::IDX_OUT_W+7)'(BUCKET_COUNT);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_bucket_index))
        else $error("stalled result item changed");

    // Front end goes busy hashing after each accepted item
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while hashing");

    // Only defined status codes leave the block
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == cht_pkg::ST_OK || o_status == cht_pkg::ST_MISS
                         || o_status == cht_pkg::ST_FULL))
        else $error("undefined status code");

    // Bucket index stays in range where the port can show it whole
    a_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((cht_pkg::IDX_OUT_W+7)'(o_bucket_index) < idx_limit))
        else $error("bucket index out of range");

endmodule

bind chained_hash_table_top cht_checker #(.BUCKET_COUNT(BUCKET_COUNT)) u_cht_checker (.*);
